// ----- design/fdc_pkg.sv -----
// Shared types and constants for the fixed frame deframer and checker.
`default_nettype none

package fdc_pkg;

    localparam int FRAME_BYTES_DEF = 256;
    localparam int HDR_BYTES       = 10;
    localparam int SYNC_BYTES      = 4;
    localparam int TRAILER_BYTES   = 2;

    localparam logic [31:0] SYNC_WORD_RESET = 32'h4341_5449;

    // header byte positions
    localparam int POS_DTYPE_HI = 4;
    localparam int POS_DTYPE_LO = 5;
    localparam int POS_DID_HI   = 6;
    localparam int POS_DID_LO   = 7;
    localparam int POS_LENGTH   = 8;
    localparam int POS_SEQUENCE = 9;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SYNC  = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_BAD_CSUM  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [1:0]  status;
        logic [15:0] unit_type;
        logic [15:0] unit_id;
        logic [7:0]  length_field;
        logic [7:0]  sequence_res;
    } res_t;

endpackage

`default_nettype wire

// ----- design/fdc_in_if.sv -----
// Input byte channel interface.
`default_nettype none

interface fdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// ----- design/fdc_out_if.sv -----
// Result channel interface.
`default_nettype none

interface fdc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [1:0]  status;
    logic [15:0] unit_type;
    logic [15:0] unit_id;
    logic [7:0]  length_field;
    logic [7:0]  sequence_res;

    modport source (
        output valid, output kind, output payload_byte, output payload_index,
        output status, output unit_type, output unit_id,
        output length_field, output sequence_res, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input payload_index,
        input status, input unit_type, input unit_id,
        input length_field, input sequence_res, output ready
    );
endinterface

`default_nettype wire

// ----- design/fixed_frame_deframer_checker.sv -----
// Top level of the fixed frame deframer and checker.
//
// Takes one frame byte per cycle, unless the output stalls, and passes each
// payload byte out as it arrives, followed by one verdict transfer (status
// plus header fields) on the last byte of each FRAME_BYTES-byte frame.
// Sustained rate is one byte per cycle while output ready stays high; a byte
// passes through the input register, then the combinational frame state
// update into the result register. Input ready follows output ready
// combinationally through the two register stages. The sync word register
// may only be written while no frame bytes are in flight.
`default_nettype none

module fixed_frame_deframer_checker #(
    parameter int FRAME_BYTES = fdc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    fdc_in_if.sink           in_chan,
    fdc_out_if.source        out_chan
);
    import fdc_pkg::*;

    localparam logic [7:0] LEN_MAX = 8'(FRAME_BYTES - 12);

    logic [31:0] sync_word_reg;
    item_t       item;
    res_t        res;
    logic        has_res;
    logic        step;
    logic        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= SYNC_WORD_RESET;
        end
        else if (cfg_wr_en)
        begin
            sync_word_reg <= cfg_wr_data;
        end
    end

    fdc_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_free (out_free),
        .item     (item),
        .step     (step)
    );

    fdc_check #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .sync_word (sync_word_reg),
        .res       (res),
        .has_res   (has_res)
    );

    fdc_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .has_res  (has_res),
        .res      (res),
        .out_free (out_free),
        .out_chan (out_chan)
    );

    // bad length verdict only for an oversized length byte
    a_bad_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && out_chan.kind == KIND_VERDICT && out_chan.status == ST_BAD_LEN)
        |-> (out_chan.length_field > LEN_MAX))
        else $error("bad length verdict with length in range");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && out_chan.kind == KIND_VERDICT && out_chan.status == ST_OK)
        |-> (out_chan.length_field <= LEN_MAX))
        else $error("ok verdict with oversized length");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && out_chan.kind == KIND_PAYLOAD)
        |-> (out_chan.status == ST_OK && out_chan.length_field == 8'd0
             && out_chan.unit_type == 16'd0))
        else $error("payload transfer carries verdict fields");

    // a result held off by the receiver stays put
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && !out_chan.ready)
        |=> (out_chan.valid && $stable(out_chan.kind) && $stable(out_chan.payload_byte)
             && $stable(out_chan.payload_index) && $stable(out_chan.status)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- design/fdc_in_reg.sv -----
// Input register stage with ready chained from the result stage.
`default_nettype none

module fdc_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fdc_in_if.sink             in_chan,
    input  wire logic          out_free,
    output fdc_pkg::item_t     item,
    output logic               step
);
    import fdc_pkg::*;

    logic  s0_valid_reg;
    item_t item_reg;
    logic  accept;

    assign step          = s0_valid_reg && out_free;
    assign in_chan.ready = !s0_valid_reg || out_free;
    assign accept        = in_chan.valid && in_chan.ready;
    assign item          = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s0_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            s0_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte   <= in_chan.data_byte;
            item_reg.frame_start <= in_chan.frame_start;
        end
    end

endmodule

`default_nettype wire

// ----- design/fdc_check.sv -----
// Frame state, checksum accumulation and verdict logic, one byte per step.
`default_nettype none

module fdc_check #(
    parameter int FRAME_BYTES = fdc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire fdc_pkg::item_t item,
    input  wire logic [31:0]   sync_word,
    output fdc_pkg::res_t      res,
    output logic               has_res
);
    import fdc_pkg::*;

    localparam int          POS_W    = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] CSUM_POS = POS_W'(FRAME_BYTES - TRAILER_BYTES);
    localparam logic [POS_W-1:0] HDR_POS  = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] SYNC_END = POS_W'(SYNC_BYTES);
    localparam logic [7:0]  LEN_MAX  = 8'(FRAME_BYTES - 12);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic             sync_reg, sync_next;
    logic [15:0]      dtype_reg, dtype_next;
    logic [15:0]      did_reg, did_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       seq_reg, seq_next;
    logic [7:0]       csum_hi_reg, csum_hi_next;

    logic [POS_W-1:0] p;
    logic [POS_W-1:0] p_off;
    logic [15:0]      sum_base;
    logic             sync_base;
    logic [7:0]       want;
    logic [7:0]       b;
    logic             in_hdr;
    logic             is_payload;
    logic             is_last;
    logic [15:0]      rx_csum;

    always_comb
    begin
        b          = item.data_byte;
        p          = item.frame_start ? '0 : pos_reg;
        sum_base   = item.frame_start ? 16'd0 : sum_reg;
        sync_base  = item.frame_start ? 1'b1 : sync_reg;
        p_off      = p - HDR_POS;
        in_hdr     = p < HDR_POS;
        is_payload = !in_hdr && (p < CSUM_POS) && (8'(p_off) < len_reg);
        is_last    = p == LAST_POS;
        rx_csum    = {csum_hi_reg, b};

        case (p[1:0])
            2'd0:    want = sync_word[31:24];
            2'd1:    want = sync_word[23:16];
            2'd2:    want = sync_word[15:8];
            default: want = sync_word[7:0];
        endcase

        sync_next    = sync_base && !((p < SYNC_END) && (want != b));
        dtype_next   = dtype_reg;
        did_next     = did_reg;
        len_next     = len_reg;
        seq_next     = seq_reg;
        csum_hi_next = csum_hi_reg;
        if (p == POS_W'(POS_DTYPE_HI)) dtype_next = {b, 8'd0};
        if (p == POS_W'(POS_DTYPE_LO)) dtype_next = {dtype_reg[15:8], b};
        if (p == POS_W'(POS_DID_HI))   did_next   = {b, 8'd0};
        if (p == POS_W'(POS_DID_LO))   did_next   = {did_reg[15:8], b};
        if (p == POS_W'(POS_LENGTH))   len_next   = b;
        if (p == POS_W'(POS_SEQUENCE)) seq_next   = b;
        if (p == CSUM_POS)             csum_hi_next = b;

        sum_next = (in_hdr || is_payload) ? sum_base + 16'(b) : sum_base;
        pos_next = p + POS_W'(1);

        res     = '0;
        has_res = 1'b0;
        if (is_payload)
        begin
            has_res           = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = b;
            res.payload_index = 8'(p_off);
        end
        if (is_last)
        begin
            has_res            = 1'b1;
            res.kind           = KIND_VERDICT;
            res.unit_type      = dtype_reg;
            res.unit_id        = did_reg;
            res.length_field   = len_reg;
            res.sequence_res   = seq_reg;
            if (!sync_base)
                res.status = ST_BAD_SYNC;
            else if (len_reg > LEN_MAX)
                res.status = ST_BAD_LEN;
            else if (rx_csum != sum_base)
                res.status = ST_BAD_CSUM;
            else
                res.status = ST_OK;
            pos_next  = '0;
            sum_next  = 16'd0;
            sync_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            sum_reg     <= 16'd0;
            sync_reg    <= 1'b1;
            dtype_reg   <= 16'd0;
            did_reg     <= 16'd0;
            len_reg     <= 8'd0;
            seq_reg     <= 8'd0;
            csum_hi_reg <= 8'd0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            sync_reg    <= sync_next;
            dtype_reg   <= dtype_next;
            did_reg     <= did_next;
            len_reg     <= len_next;
            seq_reg     <= seq_next;
            csum_hi_reg <= csum_hi_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/fdc_out_reg.sv -----
// Result register driving the output channel.
`default_nettype none

module fdc_out_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          has_res,
    input  wire fdc_pkg::res_t res,
    output logic               out_free,
    fdc_out_if.source          out_chan
);
    import fdc_pkg::*;

    logic out_valid_reg;
    res_t res_reg;
    logic load;

    assign load     = step && has_res;
    assign out_free = !out_valid_reg || out_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_chan.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_chan.valid          = out_valid_reg;
    assign out_chan.kind           = res_reg.kind;
    assign out_chan.payload_byte   = res_reg.payload_byte;
    assign out_chan.payload_index  = res_reg.payload_index;
    assign out_chan.status         = res_reg.status;
    assign out_chan.unit_type      = res_reg.unit_type;
    assign out_chan.unit_id        = res_reg.unit_id;
    assign out_chan.length_field   = res_reg.length_field;
    assign out_chan.sequence_res   = res_reg.sequence_res;

endmodule

`default_nettype wire

// ----- tb/fixed_frame_deframer_checker_tb.sv -----
// Testbench for the fixed frame deframer and checker, with a scoreboard that predicts its results.
`timescale 1ns / 1ps

module fixed_frame_deframer_checker_tb;
    import fdc_pkg::*;

    localparam int FRAME_LEN    = FRAME_BYTES_DEF;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 8;

    class frame_verdict_board;
        logic [31:0] sync_word;
        int unsigned pos;
        logic [15:0] sum;
        bit          sync_ok;
        logic [15:0] dtype;
        logic [15:0] did;
        logic [7:0]  len;
        logic [7:0]  seq;
        logic [7:0]  csum_hi;
        res_t        due[$];
        int          errors;

        function new();
            sync_word = SYNC_WORD_RESET;
            dtype = '0;
            did = '0;
            len = '0;
            seq = '0;
            csum_hi = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            pos = 0;
            sum = '0;
            sync_ok = 1'b1;
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            res_t r;
            if (start)
                restart();
            r = '0;
            if (pos < SYNC_BYTES && b != sync_word[31 - 8 * pos -: 8])
                sync_ok = 1'b0;
            case (pos)
                POS_DTYPE_HI: dtype = {b, 8'h00};
                POS_DTYPE_LO: dtype[7:0] = b;
                POS_DID_HI:   did = {b, 8'h00};
                POS_DID_LO:   did[7:0] = b;
                POS_LENGTH:   len = b;
                POS_SEQUENCE: seq = b;
                default: ;
            endcase
            if (pos < HDR_BYTES) begin
                sum += b;
            end
            else if (pos < FRAME_LEN - TRAILER_BYTES && pos - HDR_BYTES < len) begin
                sum += b;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.payload_index = 8'(pos - HDR_BYTES);
                due.push_back(r);
            end
            if (pos == FRAME_LEN - 2)
                csum_hi = b;
            if (pos >= FRAME_LEN - 1) begin
                r = '0;
                r.kind = KIND_VERDICT;
                if (!sync_ok)
                    r.status = ST_BAD_SYNC;
                else if (len > FRAME_LEN - 12)
                    r.status = ST_BAD_LEN;
                else if ({csum_hi, b} != sum)
                    r.status = ST_BAD_CSUM;
                else
                    r.status = ST_OK;
                r.unit_type = dtype;
                r.unit_id = did;
                r.length_field = len;
                r.sequence_res = seq;
                due.push_back(r);
                restart();
            end
            else begin
                pos = (pos + 1) & 8'hff;
            end
        endfunction

        function void cmp(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: result with nothing due, expected none actual kind %0d",
                         $time, got.kind);
                return;
            end
            want = due.pop_front();
            cmp("kind", want.kind, got.kind);
            cmp("payload_byte", want.payload_byte, got.payload_byte);
            cmp("payload_index", want.payload_index, got.payload_index);
            cmp("status", want.status, got.status);
            cmp("unit_type", want.unit_type, got.unit_type);
            cmp("unit_id", want.unit_id, got.unit_id);
            cmp("length_field", want.length_field, got.length_field);
            cmp("sequence_res", want.sequence_res, got.sequence_res);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    int          in_count;
    int          burst_left;
    int          bytes_sent;
    bit          aligned;

    frame_verdict_board sb = new();

    fdc_in_if  in_chan();
    fdc_out_if out_chan();

    fixed_frame_deframer_checker #(
        .FRAME_BYTES(FRAME_LEN)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_chan     (in_chan),
        .out_chan    (out_chan)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_chan.valid && in_chan.ready)
        begin
            sb.note_byte(in_chan.data_byte, in_chan.frame_start);
            in_count <= in_count + 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_chan.valid && out_chan.ready)
            sb.check_result('{kind: out_chan.kind, payload_byte: out_chan.payload_byte,
                              payload_index: out_chan.payload_index, status: out_chan.status,
                              unit_type: out_chan.unit_type, unit_id: out_chan.unit_id,
                              length_field: out_chan.length_field,
                              sequence_res: out_chan.sequence_res});
    end

    // receiver stalls: randomly chosen patterns, one long hold-off
    initial
    begin
        int  mode;
        int  left;
        int  hold;
        bit  held_done;
        int  cyc;
        mode = 0;
        left = 0;
        hold = 0;
        held_done = 1'b0;
        cyc = 0;
        out_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held_done && in_count >= HOLD_AT)
            begin
                held_done = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_chan.ready <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(32, 256);
                end
                left--;
                case (mode)
                    0: out_chan.ready <= 1'b1;
                    1: out_chan.ready <= ($urandom_range(0, 3) != 0);
                    2: out_chan.ready <= ($urandom_range(0, 3) == 0);
                    default: out_chan.ready <= (cyc % 5 != 0);
                endcase
            end
        end
    end

    task automatic drive_byte(input logic [7:0] b, input logic s);
        if (burst_left == 0)
        begin
            in_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
        end
        in_chan.valid <= 1'b1;
        in_chan.data_byte <= b;
        in_chan.frame_start <= s;
        do @(posedge clk); while (!in_chan.ready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [31:0] sync_v, input logic [15:0] dtype,
                              input logic [15:0] did, input logic [7:0] len,
                              input logic [7:0] seq, input bit csum_ok,
                              input bit first_start, input int stop_after);
        logic [7:0]  fr [FRAME_LEN];
        logic [15:0] csum;
        csum = '0;
        for (int i = 0; i < SYNC_BYTES; i++)
            fr[i] = sync_v[31 - 8 * i -: 8];
        fr[POS_DTYPE_HI] = dtype[15:8];
        fr[POS_DTYPE_LO] = dtype[7:0];
        fr[POS_DID_HI] = did[15:8];
        fr[POS_DID_LO] = did[7:0];
        fr[POS_LENGTH] = len;
        fr[POS_SEQUENCE] = seq;
        for (int p = HDR_BYTES; p < FRAME_LEN - TRAILER_BYTES; p++)
            fr[p] = 8'($urandom);
        for (int p = 0; p < FRAME_LEN - TRAILER_BYTES; p++)
            if (p < HDR_BYTES || p - HDR_BYTES < len)
                csum += 16'(fr[p]);
        if (!csum_ok)
            csum ^= 16'($urandom_range(1, 65535));
        fr[FRAME_LEN - 2] = csum[15:8];
        fr[FRAME_LEN - 1] = csum[7:0];
        for (int p = 0; p < stop_after; p++)
            drive_byte(fr[p], (p == 0) ? first_start : 1'b0);
        aligned = (stop_after == FRAME_LEN);
    endtask

    task automatic write_sync(input logic [31:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.sync_word = v;
    endtask

    task automatic drain;
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (sb.due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_traffic(input int n_bytes);
        int          first;
        int          pick;
        int          len;
        logic [31:0] sv;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(245, 255)
                                                  : $urandom_range(0, 244);
                sv = sb.sync_word;
                if ($urandom_range(0, 6) == 0)
                    sv ^= 32'd1 << $urandom_range(0, 31);
                send_frame(sv, 16'($urandom), 16'($urandom), 8'(len), 8'($urandom),
                           $urandom_range(0, 4) != 0,
                           aligned ? 1'($urandom_range(0, 1)) : 1'b1, FRAME_LEN);
            end
            else if (pick < 85)
            begin
                send_frame(sb.sync_word, 16'($urandom), 16'($urandom), 8'($urandom),
                           8'($urandom), 1'b1,
                           aligned ? 1'($urandom_range(0, 1)) : 1'b1,
                           $urandom_range(1, FRAME_LEN - 1));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    drive_byte(8'($urandom), $urandom_range(0, 3) == 0);
                aligned = 1'b0;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_chan.valid <= 1'b0;
        in_chan.data_byte <= '0;
        in_chan.frame_start <= 1'b0;
        in_count <= 0;
        burst_left = 0;
        bytes_sent = 0;
        aligned = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sync word: every verdict, priorities, extremes
        send_frame(SYNC_WORD_RESET, 16'h0000, 16'hffff, 8'd244, 8'hff, 1'b1, 1'b1, FRAME_LEN);
        send_frame(SYNC_WORD_RESET ^ 32'hff00_0000, 16'hffff, 16'h0000, 8'd255, 8'h00,
                   1'b0, 1'b0, FRAME_LEN);
        send_frame(SYNC_WORD_RESET, 16'($urandom), 16'($urandom), 8'd245, 8'h01,
                   1'b0, 1'b0, FRAME_LEN);
        send_frame(SYNC_WORD_RESET, 16'($urandom), 16'($urandom), 8'd0, 8'h02,
                   1'b0, 1'b0, FRAME_LEN);
        // frames dropped by a new start: mid-payload, after one byte
        send_frame(SYNC_WORD_RESET, 16'($urandom), 16'($urandom), 8'd60, 8'h03,
                   1'b1, 1'b0, 40);
        send_frame(SYNC_WORD_RESET, 16'($urandom), 16'($urandom), 8'd9, 8'h04,
                   1'b1, 1'b1, 1);
        drain();

        write_sync($urandom);
        aligned = 1'b0;
        random_traffic(150);
        drain();

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
